// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the probe statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRS_ASSERT_IMPL(lbl, ante, cons)
`define PRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/prs_pkg.sv
// Package with widths, codes, types and structs of the probe statistics block.
package prs_pkg;
  localparam int RTT_W       = 16;
  localparam int CNT_W       = 16;
  localparam int SUM_W       = 32;
  localparam int LOSS_W      = 7;
  localparam int OP_W        = 3;
  localparam int ERR_W       = 2;
  localparam int PCT_W       = 7;
  localparam int PROD_W      = CNT_W + PCT_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_REPLY   = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd2;
  localparam logic [OP_W-1:0] OP_END     = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CANCELED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_REPLY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEXT,
    S_WAIT,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    SEL_MEAN,
    SEL_JIT,
    SEL_LOSS
  } div_sel_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;
endpackage

// File: hw/rtl/probe_rtt_statistics.sv
// Top level of the probe session statistics block: event sequencer and statistics registers.
// Each accepted event goes through S_NEXT, then through the shared 32-step divider once for
// each division it owes (none for start, cancel and ignored events, at most one for timeout
// and end, up to three for a reply: mean, jitter, loss); S_DONE then loads the output stage.
// A new event is taken only in S_IDLE; S_DONE waits while a result still waits on out_ready.
// Reset (rst_n low at a clock edge) clears every statistic, all flags and out_valid.
`include "assert_macros.svh"
module probe_rtt_statistics (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prs_pkg::OP_W-1:0]      in_opcode,
  input  logic [prs_pkg::RTT_W-1:0]     in_rtt_ms,
  input  logic [prs_pkg::CNT_W-1:0]     in_sent_count,
  input  logic [prs_pkg::CNT_W-1:0]     in_reply_total,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_running,
  output logic                          out_stats_valid,
  output logic [prs_pkg::ERR_W-1:0]     out_error_code,
  output logic [prs_pkg::RTT_W-1:0]     out_last_rtt,
  output logic [prs_pkg::RTT_W-1:0]     out_min_rtt,
  output logic [prs_pkg::RTT_W-1:0]     out_max_rtt,
  output logic [prs_pkg::RTT_W-1:0]     out_mean_rtt,
  output logic [prs_pkg::RTT_W-1:0]     out_mean_jitter,
  output logic [prs_pkg::LOSS_W-1:0]    out_loss_pct
);
  // Sequencer state and the divisions still owed by the current transaction.
  prs_pkg::seq_state_t state_r, state_nxt;
  prs_pkg::div_sel_t   sel_r, sel_nxt;
  logic need_mean_r, need_mean_nxt;
  logic need_jit_r, need_jit_nxt;
  logic need_loss_r, need_loss_nxt;

  // Session statistics.
  logic [prs_pkg::SUM_W-1:0]  rtt_sum_r, rtt_sum_nxt;
  logic [prs_pkg::CNT_W-1:0]  reply_seen_r, reply_seen_nxt;
  logic [prs_pkg::RTT_W-1:0]  prev_rtt_r, prev_rtt_nxt;
  logic [prs_pkg::SUM_W-1:0]  jitter_sum_r, jitter_sum_nxt;
  logic [prs_pkg::CNT_W-1:0]  jitter_samples_r, jitter_samples_nxt;
  logic [prs_pkg::RTT_W-1:0]  last_r, last_nxt;
  logic [prs_pkg::RTT_W-1:0]  min_r, min_nxt;
  logic [prs_pkg::RTT_W-1:0]  max_r, max_nxt;
  logic [prs_pkg::RTT_W-1:0]  mean_r, mean_nxt;
  logic [prs_pkg::RTT_W-1:0]  jitter_r, jitter_nxt;
  logic [prs_pkg::LOSS_W-1:0] loss_r, loss_nxt;
  logic                       run_r, run_nxt;
  logic                       valid_r, valid_nxt;
  logic                       cancel_r, cancel_nxt;
  logic [prs_pkg::ERR_W-1:0]  err_r, err_nxt;

  // Per-transaction latches: accept bit and the counts used for loss.
  logic                       acc_r, acc_nxt;
  logic [prs_pkg::CNT_W-1:0]  sent_r, sent_nxt;
  logic [prs_pkg::CNT_W-1:0]  got_r, got_nxt;

  // Output stage, so that a result can wait while the next transaction is taken.
  logic                       out_valid_r;
  logic                       load_out;

  prs_pkg::div_req_t div_req;
  prs_pkg::div_rsp_t div_rsp;

  logic                       accept;
  logic                       session_open;
  logic [prs_pkg::SUM_W:0]    rtt_sum_ext;
  logic [prs_pkg::SUM_W:0]    jit_sum_ext;
  logic [prs_pkg::RTT_W-1:0]  rtt_delta;
  logic [prs_pkg::CNT_W-1:0]  lost;
  logic [prs_pkg::PROD_W-1:0] lost_scaled;
  logic [prs_pkg::SUM_W-1:0]  loss_dividend;
  logic [prs_pkg::RTT_W-1:0]  quot_clamped;
  logic                       any_need;

  assign in_ready     = (state_r == prs_pkg::S_IDLE);
  assign accept       = in_valid && in_ready;
  assign session_open = run_r || cancel_r;
  assign any_need     = need_mean_r || need_jit_r || need_loss_r;

  // Saturating sums for the running totals; a carry out pins the sum at all ones.
  assign rtt_sum_ext = {1'b0, rtt_sum_r} + {{(prs_pkg::SUM_W + 1 - prs_pkg::RTT_W){1'b0}},
                                             in_rtt_ms};
  assign rtt_delta   = (in_rtt_ms >= prev_rtt_r) ? (in_rtt_ms - prev_rtt_r)
                                                 : (prev_rtt_r - in_rtt_ms);
  assign jit_sum_ext = {1'b0, jitter_sum_r} + {{(prs_pkg::SUM_W + 1 - prs_pkg::RTT_W){1'b0}},
                                                rtt_delta};

  // Loss is the rounded ratio (lost * 100 + sent / 2) / sent. Replies beyond the
  // sent count mean no loss.
  assign lost          = (sent_r > got_r) ? (sent_r - got_r) : '0;
  assign lost_scaled   = lost * prs_pkg::PCT_FULL;
  assign loss_dividend = prs_pkg::SUM_W'(lost_scaled) + prs_pkg::SUM_W'(sent_r >> 1);

  // The mean and the mean jitter saturate at the RTT range.
  assign quot_clamped = (div_rsp.quotient[prs_pkg::SUM_W-1:prs_pkg::RTT_W] != '0)
                        ? '1 : div_rsp.quotient[prs_pkg::RTT_W-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prs_pkg::S_IDLE: if (accept) state_nxt = prs_pkg::S_NEXT;
      prs_pkg::S_NEXT: state_nxt = any_need ? prs_pkg::S_WAIT : prs_pkg::S_DONE;
      prs_pkg::S_WAIT: if (div_rsp.done) state_nxt = prs_pkg::S_NEXT;
      prs_pkg::S_DONE: if (!out_valid_r || out_ready) state_nxt = prs_pkg::S_IDLE;
      default:         state_nxt = prs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: divider requests and the output-stage load.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = rtt_sum_r;
    div_req.divisor  = reply_seen_r;
    load_out         = 1'b0;
    unique case (state_r)
      prs_pkg::S_NEXT: begin
        div_req.start = any_need;
        priority if (need_mean_r) begin
          div_req.dividend = rtt_sum_r;
          div_req.divisor  = reply_seen_r;
        end else if (need_jit_r) begin
          div_req.dividend = jitter_sum_r;
          div_req.divisor  = jitter_samples_r;
        end else begin
          div_req.dividend = loss_dividend;
          div_req.divisor  = sent_r;
        end
      end
      prs_pkg::S_DONE: load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Statistics update. An accepted transaction applies everything that needs no
  // division at once and marks the divisions it owes; the sequencer then runs them
  // through the shared divider one after the other.
  always_comb begin
    rtt_sum_nxt        = rtt_sum_r;
    reply_seen_nxt     = reply_seen_r;
    prev_rtt_nxt       = prev_rtt_r;
    jitter_sum_nxt     = jitter_sum_r;
    jitter_samples_nxt = jitter_samples_r;
    last_nxt           = last_r;
    min_nxt            = min_r;
    max_nxt            = max_r;
    mean_nxt           = mean_r;
    jitter_nxt         = jitter_r;
    loss_nxt           = loss_r;
    run_nxt            = run_r;
    valid_nxt          = valid_r;
    cancel_nxt         = cancel_r;
    err_nxt            = err_r;
    acc_nxt            = acc_r;
    sent_nxt           = sent_r;
    got_nxt            = got_r;
    need_mean_nxt      = need_mean_r;
    need_jit_nxt       = need_jit_r;
    need_loss_nxt      = need_loss_r;
    sel_nxt            = sel_r;

    if (accept) begin
      acc_nxt  = 1'b0;
      sent_nxt = in_sent_count;
      got_nxt  = in_reply_total;
      unique case (in_opcode)
        prs_pkg::OP_START: begin
          // Refused while a session (running or canceled) is still open.
          if (!session_open) begin
            rtt_sum_nxt        = '0;
            reply_seen_nxt     = '0;
            prev_rtt_nxt       = '0;
            jitter_sum_nxt     = '0;
            jitter_samples_nxt = '0;
            last_nxt           = '0;
            min_nxt            = '0;
            max_nxt            = '0;
            mean_nxt           = '0;
            jitter_nxt         = '0;
            loss_nxt           = '0;
            valid_nxt          = 1'b0;
            err_nxt            = prs_pkg::ERR_NONE;
            cancel_nxt         = 1'b0;
            run_nxt            = 1'b1;
            acc_nxt            = 1'b1;
          end
        end
        prs_pkg::OP_REPLY: begin
          if (run_r) begin
            last_nxt    = in_rtt_ms;
            rtt_sum_nxt = rtt_sum_ext[prs_pkg::SUM_W] ? '1 : rtt_sum_ext[prs_pkg::SUM_W-1:0];
            // Jitter needs a previous reply to compare against.
            if (reply_seen_r != '0) begin
              jitter_sum_nxt = jit_sum_ext[prs_pkg::SUM_W] ? '1
                               : jit_sum_ext[prs_pkg::SUM_W-1:0];
              jitter_samples_nxt = (&jitter_samples_r) ? jitter_samples_r
                                                       : jitter_samples_r + 1'b1;
              need_jit_nxt = 1'b1;
            end
            prev_rtt_nxt = in_rtt_ms;
            if (reply_seen_r == '0 || in_rtt_ms < min_r) min_nxt = in_rtt_ms;
            if (in_rtt_ms > max_r) max_nxt = in_rtt_ms;
            reply_seen_nxt = (&reply_seen_r) ? reply_seen_r : reply_seen_r + 1'b1;
            need_mean_nxt  = 1'b1;
            if (in_sent_count != '0) need_loss_nxt = 1'b1;
            else loss_nxt = '0;
            acc_nxt = 1'b1;
          end
        end
        prs_pkg::OP_TIMEOUT: begin
          if (run_r) begin
            if (in_sent_count != '0) need_loss_nxt = 1'b1;
            else loss_nxt = prs_pkg::PCT_FULL;
            acc_nxt = 1'b1;
          end
        end
        prs_pkg::OP_END: begin
          if (session_open) begin
            run_nxt   = 1'b0;
            valid_nxt = !cancel_r && (in_sent_count != '0);
            if (in_sent_count != '0) need_loss_nxt = 1'b1;
            else loss_nxt = '0;
            priority if (cancel_r)             err_nxt = prs_pkg::ERR_CANCELED;
            else if (in_reply_total == '0)     err_nxt = prs_pkg::ERR_NO_REPLY;
            else                               err_nxt = prs_pkg::ERR_NONE;
            cancel_nxt = 1'b0;
            acc_nxt    = 1'b1;
          end
        end
        prs_pkg::OP_CANCEL: begin
          if (session_open) begin
            run_nxt    = 1'b0;
            valid_nxt  = 1'b0;
            err_nxt    = prs_pkg::ERR_CANCELED;
            cancel_nxt = 1'b1;
            acc_nxt    = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Issue order is mean, then jitter, then loss; a flag drops when issued.
    if (state_r == prs_pkg::S_NEXT) begin
      priority if (need_mean_r) begin
        sel_nxt       = prs_pkg::SEL_MEAN;
        need_mean_nxt = 1'b0;
      end else if (need_jit_r) begin
        sel_nxt      = prs_pkg::SEL_JIT;
        need_jit_nxt = 1'b0;
      end else if (need_loss_r) begin
        sel_nxt       = prs_pkg::SEL_LOSS;
        need_loss_nxt = 1'b0;
      end
    end

    if (state_r == prs_pkg::S_WAIT && div_rsp.done) begin
      unique case (sel_r)
        prs_pkg::SEL_MEAN: mean_nxt   = quot_clamped;
        prs_pkg::SEL_JIT:  jitter_nxt = quot_clamped;
        prs_pkg::SEL_LOSS: loss_nxt   = div_rsp.quotient[prs_pkg::LOSS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= prs_pkg::S_IDLE;
      sel_r            <= prs_pkg::SEL_MEAN;
      need_mean_r      <= 1'b0;
      need_jit_r       <= 1'b0;
      need_loss_r      <= 1'b0;
      rtt_sum_r        <= '0;
      reply_seen_r     <= '0;
      prev_rtt_r       <= '0;
      jitter_sum_r     <= '0;
      jitter_samples_r <= '0;
      last_r           <= '0;
      min_r            <= '0;
      max_r            <= '0;
      mean_r           <= '0;
      jitter_r         <= '0;
      loss_r           <= '0;
      run_r            <= 1'b0;
      valid_r          <= 1'b0;
      cancel_r         <= 1'b0;
      err_r            <= prs_pkg::ERR_NONE;
      acc_r            <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      sel_r            <= sel_nxt;
      need_mean_r      <= need_mean_nxt;
      need_jit_r       <= need_jit_nxt;
      need_loss_r      <= need_loss_nxt;
      rtt_sum_r        <= rtt_sum_nxt;
      reply_seen_r     <= reply_seen_nxt;
      prev_rtt_r       <= prev_rtt_nxt;
      jitter_sum_r     <= jitter_sum_nxt;
      jitter_samples_r <= jitter_samples_nxt;
      last_r           <= last_nxt;
      min_r            <= min_nxt;
      max_r            <= max_nxt;
      mean_r           <= mean_nxt;
      jitter_r         <= jitter_nxt;
      loss_r           <= loss_nxt;
      run_r            <= run_nxt;
      valid_r          <= valid_nxt;
      cancel_r         <= cancel_nxt;
      err_r            <= err_nxt;
      acc_r            <= acc_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Counts and the output payload need no reset.
  always_ff @(posedge clk) begin
    sent_r <= sent_nxt;
    got_r  <= got_nxt;
    if (load_out) begin
      out_accepted    <= acc_r;
      out_running     <= run_r;
      out_stats_valid <= valid_r;
      out_error_code  <= err_r;
      out_last_rtt    <= last_r;
      out_min_rtt     <= min_r;
      out_max_rtt     <= max_r;
      out_mean_rtt    <= mean_r;
      out_mean_jitter <= jitter_r;
      out_loss_pct    <= loss_r;
    end
  end

  assign out_valid = out_valid_r;

  prs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  `PRS_ASSERT_NEXT(a_accept_busy, accept, state_r == prs_pkg::S_NEXT)
  `PRS_ASSERT_IMPL(a_start_free, div_req.start, !div_rsp.busy && !div_rsp.done)
  `PRS_ASSERT_IMPL(a_done_waiting, div_rsp.done, state_r == prs_pkg::S_WAIT)
  `PRS_ASSERT_IMPL(a_run_cancel_excl, run_r, !cancel_r)
endmodule

// File: hw/rtl/prs_div.sv
// Shared restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module prs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  prs_pkg::div_req_t req,
  output prs_pkg::div_rsp_t rsp
);
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [prs_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [prs_pkg::SUM_W-1:0]         work_r, work_nxt;
  logic [prs_pkg::CNT_W-1:0]         rem_r, rem_nxt;
  logic [prs_pkg::CNT_W-1:0]         divisor_r, divisor_nxt;
  logic [prs_pkg::CNT_W:0]           shifted;
  logic [prs_pkg::CNT_W:0]           diff;
  logic                              fits;

  localparam logic [prs_pkg::DIV_CNT_W-1:0] LAST_STEP =
    prs_pkg::DIV_CNT_W'(prs_pkg::DIV_STEPS - 1);

  assign shifted = {rem_r, work_r[prs_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign fits    = shifted >= {1'b0, divisor_r};

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    work_nxt    = work_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (req.start && !busy_r) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      work_nxt    = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[prs_pkg::CNT_W-1:0] : shifted[prs_pkg::CNT_W-1:0];
      work_nxt = {work_r[prs_pkg::SUM_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r    <= work_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = work_r;

  `PRS_ASSERT_NEXT(a_start_busy, req.start && !busy_r, busy_r)
  `PRS_ASSERT_IMPL(a_done_idle, done_r, !busy_r)
  `PRS_ASSERT_NEXT(a_last_done, busy_r && cnt_r == LAST_STEP, done_r && !busy_r)
endmodule
